// ----- src/fskm_pkg.sv -----
// ----------------------------------------------------------------------------
// fskm_pkg
// Shared types, register codes, tone codes and the quarter-sine polynomial
// for the FSK asynchronous serial modulator.
// ----------------------------------------------------------------------------
package fskm_pkg;

   // Default structural parameters
   localparam int PHASE_BITS_DEF       = 24;
   localparam int SINE_TABLE_DEPTH_DEF = 1024;
   localparam int DATA_BITS_DEF        = 8;

   // Configuration port geometry
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BAUD_LEN    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEAD_SLOTS  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAIL_SLOTS  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MARK_STEP   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPACE_STEP  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALT_STEP    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_AMPLITUDE   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_DC_OFFSET   = 3'd7;

   // Register reset values
   localparam logic [15:0]        RST_BAUD_LEN    = 16'd147;
   localparam logic [3:0]         RST_LEAD_SLOTS  = 4'd1;
   localparam logic [3:0]         RST_TAIL_SLOTS  = 4'd0;
   localparam logic [23:0]        RST_STEP        = 24'd0;
   localparam logic [14:0]        RST_AMPLITUDE   = 15'd32767;
   localparam logic signed [15:0] RST_DC_OFFSET   = 16'sd0;

   // Debug characters
   localparam logic [7:0] CH_ALT    = 8'h26;   // '&' alternate tone
   localparam logic [7:0] CH_SILENT = 8'h7E;   // '~' silence
   localparam logic [7:0] CH_MARK   = 8'h40;   // '@' mark
   localparam logic [7:0] CH_SPACE  = 8'h5E;   // '^' space

   // Tone kinds of the slot sequence
   localparam logic [1:0] TONE_FRAME  = 2'd0;
   localparam logic [1:0] TONE_ALT    = 2'd1;
   localparam logic [1:0] TONE_SILENT = 2'd2;
   localparam logic [1:0] TONE_DEBUG  = 2'd3;

   localparam int PCM_LIMIT = 32767;

   localparam longint Q30_ONE = 64'sd1073741824;

   typedef struct packed {
      logic [15:0]        baud_len;
      logic [3:0]         lead_slots;
      logic [3:0]         tail_slots;
      logic [23:0]        mark_step;
      logic [23:0]        space_step;
      logic [23:0]        alt_step;
      logic [14:0]        amplitude;
      logic signed [15:0] dc_offset;
   } cfg_type;

   // Per-transaction status from the slot sequencer
   typedef struct packed {
      logic sine_en;    // a slot is under way: add the tone to this tick
      logic accepted;   // load taken
      logic busy;       // still sending after this transaction
   } seq_stat_type;

   // sin(pi/2 * f) in Q30, odd degree-9 polynomial, truncating products.
   // Evaluated at elaboration only, to fill the quarter-wave table.
   function automatic longint quarter_sine_q30(longint f);
      longint x2;
      longint p;
      x2 = f * f / Q30_ONE;
      p  = 64'sd172272;
      p  = -64'sd5026995 + p * x2 / Q30_ONE;
      p  = 64'sd85569306 + p * x2 / Q30_ONE;
      p  = -64'sd693598668 + p * x2 / Q30_ONE;
      p  = 64'sd1686629713 + p * x2 / Q30_ONE;
      p  = p * f / Q30_ONE;
      if (p < 0) p = 0;
      if (p > Q30_ONE) p = Q30_ONE;
      return p;
   endfunction

endpackage

// ----- src/fskm_if.sv -----
// ----------------------------------------------------------------------------
// fskm_if
// Valid/ready channels of the modulator: load/tick requests in, samples and load status out.
// ----------------------------------------------------------------------------
interface fskm_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] char_byte;

   modport source (output valid, action, char_byte, input ready);
   modport sink   (input valid, action, char_byte, output ready);
endinterface

interface fskm_rsp_if;
   logic               valid;
   logic               ready;
   logic               sample_valid;
   logic signed [15:0] sample;
   logic               clipped;
   logic               accepted;
   logic               busy_res;

   modport source (output valid, sample_valid, sample, clipped, accepted, busy_res,
                   input ready);
   modport sink   (input valid, sample_valid, sample, clipped, accepted, busy_res,
                   output ready);
endinterface

// ----- src/fskm_seq.sv -----
// ----------------------------------------------------------------------------
// fskm_seq
// Slot sequencer: frame state, baud counter, tone selection and phase
// accumulator. Updates once per processed transaction.
// ----------------------------------------------------------------------------
module fskm_seq
   import fskm_pkg::*;
#(
   parameter int PHASE_BITS = PHASE_BITS_DEF,
   parameter int DATA_BITS  = DATA_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic                  action,
   input  logic [7:0]            char_byte,
   input  cfg_type               cfg,
   output logic [PHASE_BITS-1:0] phase,
   output seq_stat_type          stat
);

   localparam logic [5:0] FRAME_FIXED = 6'(DATA_BITS + 2);

   logic [7:0]            char_hold_ff,    char_hold_in;
   logic [5:0]            slot_index_ff,   slot_index_in;
   logic [5:0]            slot_total_ff,   slot_total_in;
   logic [1:0]            tone_kind_ff,    tone_kind_in;
   logic [15:0]           sample_count_ff, sample_count_in;
   logic [PHASE_BITS-1:0] phase_acc_ff,    phase_acc_in;
   logic                  sending_ff,      sending_in;

   logic        slot_mark;
   logic [5:0]  pad;
   logic [5:0]  bit_off;
   logic [23:0] step;
   logic [15:0] spb;
   logic [15:0] count_inc;
   logic [5:0]  index_inc;
   logic        slot_end;

   // Level of the current slot
   always_comb begin
      pad     = 6'(cfg.lead_slots);
      bit_off = slot_index_ff - pad - 6'd1;
      if (tone_kind_ff == TONE_DEBUG) begin
         slot_mark = (char_hold_ff == CH_MARK);
      end else if (slot_index_ff < pad) begin
         slot_mark = 1'b1;
      end else if (slot_index_ff == pad) begin
         slot_mark = 1'b0;
      end else if (bit_off < 6'(DATA_BITS)) begin
         slot_mark = char_hold_ff[bit_off[2:0]];
      end else begin
         slot_mark = 1'b1;
      end
   end

   // Phase increment for this tick
   always_comb begin
      unique case (tone_kind_ff)
         TONE_ALT:    step = cfg.alt_step;
         TONE_SILENT: step = '0;
         TONE_FRAME,
         TONE_DEBUG:  step = slot_mark ? cfg.mark_step : cfg.space_step;
      endcase
   end

   assign spb       = (cfg.baud_len == '0) ? 16'd1 : cfg.baud_len;
   assign count_inc = sample_count_ff + 16'd1;
   assign index_inc = slot_index_ff + 6'd1;
   assign slot_end  = (count_inc >= spb) || (count_inc == '0);

   // Next state
   always_comb begin
      char_hold_in    = char_hold_ff;
      slot_index_in   = slot_index_ff;
      slot_total_in   = slot_total_ff;
      tone_kind_in    = tone_kind_ff;
      sample_count_in = sample_count_ff;
      phase_acc_in    = phase_acc_ff;
      sending_in      = sending_ff;
      if (fire && action && !sending_ff) begin
         // start a frame or a single debug slot
         char_hold_in    = char_byte;
         slot_index_in   = '0;
         sample_count_in = '0;
         phase_acc_in    = '0;
         sending_in      = 1'b1;
         slot_total_in   = 6'd1;
         priority if (char_byte == CH_ALT) begin
            tone_kind_in = TONE_ALT;
         end else if (char_byte == CH_SILENT) begin
            tone_kind_in = TONE_SILENT;
         end else if (char_byte == CH_MARK || char_byte == CH_SPACE) begin
            tone_kind_in = TONE_DEBUG;
         end else begin
            tone_kind_in  = TONE_FRAME;
            slot_total_in = 6'(cfg.lead_slots) + FRAME_FIXED + 6'(cfg.tail_slots);
         end
      end else if (fire && !action && sending_ff) begin
         // advance one sample; at slot end restart phase and move to next slot
         if (slot_end) begin
            sample_count_in = '0;
            phase_acc_in    = '0;
            slot_index_in   = index_inc;
            if (index_inc >= slot_total_ff || index_inc == '0) begin
               sending_in = 1'b0;
            end
         end else begin
            sample_count_in = count_inc;
            phase_acc_in    = phase_acc_ff + PHASE_BITS'(step);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_hold_ff    <= '0;
         slot_index_ff   <= '0;
         slot_total_ff   <= '0;
         tone_kind_ff    <= TONE_FRAME;
         sample_count_ff <= '0;
         phase_acc_ff    <= '0;
         sending_ff      <= 1'b0;
      end else begin
         char_hold_ff    <= char_hold_in;
         slot_index_ff   <= slot_index_in;
         slot_total_ff   <= slot_total_in;
         tone_kind_ff    <= tone_kind_in;
         sample_count_ff <= sample_count_in;
         phase_acc_ff    <= phase_acc_in;
         sending_ff      <= sending_in;
      end
   end

   assign phase         = phase_acc_ff;
   assign stat.sine_en  = sending_ff;
   assign stat.accepted = action && !sending_ff;
   assign stat.busy     = sending_in;

endmodule

// ----- src/fskm_sine.sv -----
// ----------------------------------------------------------------------------
// fskm_sine
// Quarter-wave sine table lookup scaled by the amplitude, with quadrant
// mirroring and sign. SINE_TABLE_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module fskm_sine
   import fskm_pkg::*;
#(
   parameter int PHASE_BITS       = PHASE_BITS_DEF,
   parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
   input  logic [PHASE_BITS-1:0] phase,
   input  logic [14:0]           amplitude,
   output logic signed [15:0]    wave
);

   localparam int ABITS  = $clog2(SINE_TABLE_DEPTH);
   localparam int QBITS  = ABITS - 2;
   localparam int QDEPTH = SINE_TABLE_DEPTH / 4;
   localparam int QSHIFT = 30 - QBITS;
   localparam logic [30:0] QS_FULL = 31'(quarter_sine_q30(Q30_ONE));

   logic [30:0]       qtab [QDEPTH];
   logic [ABITS-1:0]  k;
   logic [1:0]        quad;
   logic [QBITS-1:0]  low;
   logic [QBITS-1:0]  mirror;
   logic [30:0]       s;
   logic [45:0]       prod;
   logic [15:0]       mag;

   // Quarter-wave table, built at elaboration
   for (genvar j = 0; j < QDEPTH; j++) begin : g_tab
      assign qtab[j] = 31'(quarter_sine_q30(longint'(j) <<< QSHIFT));
   end

   // Quantize the phase and fold into the first quadrant
   assign k      = phase[PHASE_BITS-1 -: ABITS];
   assign quad   = k[ABITS-1 -: 2];
   assign low    = k[QBITS-1:0];
   assign mirror = '0 - low;

   always_comb begin
      if (!quad[0]) begin
         s = qtab[low];
      end else if (low == '0) begin
         s = QS_FULL;
      end else begin
         s = qtab[mirror];
      end
   end

   // Scale by amplitude, truncate, apply sign of lower half-turn
   assign prod = 46'(amplitude) * 46'(s);
   assign mag  = {1'b0, prod[44:30]};
   assign wave = quad[1] ? $signed(16'd0 - mag) : $signed(mag);

endmodule

// ----- src/fsk_async_serial_modulator.sv -----
// ----------------------------------------------------------------------------
// fsk_async_serial_modulator
// FSK asynchronous serial modulator producing one PCM sample per tick.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch transactions: action 1 loads char_byte (ignored while a frame or
//   debug slot is still being sent), action 0 is a sample tick. Each request
//   yields one rsp_ch transaction: a tick gives sample_valid 1 with the PCM
//   sample (saturated to +/-32767, clipped flags it), a load gives accepted;
//   busy_res tells whether sending goes on. csr_wr_en writes csr_wr_data to
//   register csr_index; write only while the block is idle.
// Timing:
//   One transaction per cycle sustained while rsp_ch.ready stays high. A
//   request is held in the input register while the sequencer update, table
//   lookup, amplitude multiply and saturation run into the result register;
//   rsp_ch.valid rises when the result register is loaded.
// Reset and stalls:
//   Synchronous reset empties both registers, idles the sequencer and loads
//   register defaults. When rsp_ch.ready is low the result holds, the input
//   register still takes one more transaction, then req_ch.ready drops.
// ----------------------------------------------------------------------------
module fsk_async_serial_modulator
   import fskm_pkg::*;
#(
   parameter int PHASE_BITS       = PHASE_BITS_DEF,
   parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
   parameter int DATA_BITS        = DATA_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   fskm_req_if.sink               req_ch,
   fskm_rsp_if.source             rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   localparam logic signed [16:0] PCM_MAX = 17'(PCM_LIMIT);
   localparam logic signed [16:0] PCM_MIN = -17'(PCM_LIMIT);

   cfg_type cfg_ff;

   logic       in_valid_ff;
   logic       in_action_ff;
   logic [7:0] in_char_ff;

   logic               out_valid_ff;
   logic               out_sample_valid_ff, out_sample_valid_in;
   logic signed [15:0] out_sample_ff,       out_sample_in;
   logic               out_clipped_ff,      out_clipped_in;
   logic               out_accepted_ff,     out_accepted_in;
   logic               out_busy_ff;

   logic                  out_free;
   logic                  fire;
   logic [PHASE_BITS-1:0] phase;
   seq_stat_type          stat;
   logic signed [15:0]    wave;
   logic signed [16:0]    sum;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.baud_len   <= RST_BAUD_LEN;
         cfg_ff.lead_slots <= RST_LEAD_SLOTS;
         cfg_ff.tail_slots <= RST_TAIL_SLOTS;
         cfg_ff.mark_step  <= RST_STEP;
         cfg_ff.space_step <= RST_STEP;
         cfg_ff.alt_step   <= RST_STEP;
         cfg_ff.amplitude  <= RST_AMPLITUDE;
         cfg_ff.dc_offset  <= RST_DC_OFFSET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BAUD_LEN:   cfg_ff.baud_len   <= csr_wr_data[15:0];
            CSR_LEAD_SLOTS: cfg_ff.lead_slots <= csr_wr_data[3:0];
            CSR_TAIL_SLOTS: cfg_ff.tail_slots <= csr_wr_data[3:0];
            CSR_MARK_STEP:  cfg_ff.mark_step  <= csr_wr_data;
            CSR_SPACE_STEP: cfg_ff.space_step <= csr_wr_data;
            CSR_ALT_STEP:   cfg_ff.alt_step   <= csr_wr_data;
            CSR_AMPLITUDE:  cfg_ff.amplitude  <= csr_wr_data[14:0];
            CSR_DC_OFFSET:  cfg_ff.dc_offset  <= $signed(csr_wr_data[15:0]);
         endcase
      end
   end

   // Handshake: the result register frees when empty or taken
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_action_ff <= req_ch.action;
         in_char_ff   <= req_ch.char_byte;
      end
   end

   fskm_seq #(
      .PHASE_BITS (PHASE_BITS),
      .DATA_BITS  (DATA_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .action    (in_action_ff),
      .char_byte (in_char_ff),
      .cfg       (cfg_ff),
      .phase     (phase),
      .stat      (stat)
   );

   fskm_sine #(
      .PHASE_BITS       (PHASE_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_sine (
      .phase     (phase),
      .amplitude (cfg_ff.amplitude),
      .wave      (wave)
   );

   // Offset, add tone while sending, saturate
   assign sum = 17'(cfg_ff.dc_offset) + (stat.sine_en ? 17'(wave) : 17'sd0);

   always_comb begin
      out_sample_valid_in = 1'b0;
      out_sample_in       = '0;
      out_clipped_in      = 1'b0;
      out_accepted_in     = 1'b0;
      if (in_action_ff) begin
         out_accepted_in = stat.accepted;
      end else begin
         out_sample_valid_in = 1'b1;
         priority if (sum > PCM_MAX) begin
            out_sample_in  = 16'(PCM_MAX);
            out_clipped_in = 1'b1;
         end else if (sum < PCM_MIN) begin
            out_sample_in  = 16'(PCM_MIN);
            out_clipped_in = 1'b1;
         end else begin
            out_sample_in = sum[15:0];
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_sample_valid_ff <= out_sample_valid_in;
         out_sample_ff       <= out_sample_in;
         out_clipped_ff      <= out_clipped_in;
         out_accepted_ff     <= out_accepted_in;
         out_busy_ff         <= stat.busy;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.sample_valid = out_sample_valid_ff;
   assign rsp_ch.sample       = out_sample_ff;
   assign rsp_ch.clipped      = out_clipped_ff;
   assign rsp_ch.accepted     = out_accepted_ff;
   assign rsp_ch.busy_res     = out_busy_ff;

endmodule

// ----- src/fskm_checker.sv -----
// ----------------------------------------------------------------------------
// fskm_checker
// Port-level checks on the modulator's result channel, bound to the top.
// ----------------------------------------------------------------------------
module fskm_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               sample_valid,
   input logic signed [15:0] sample,
   input logic               clipped,
   input logic               accepted
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(sample) && $stable(accepted))
      else $error("stalled result changed");

   // Drop results after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Tick results never report a load taken; load results carry no sample
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (sample_valid ? !accepted : (sample == 16'sd0 && !clipped)))
      else $error("result fields mix tick and load");

   // Saturation only to the symmetric limits; full negative code never appears
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && sample_valid |->
         (sample != -16'sd32768) &&
         (!clipped || sample == 16'sd32767 || sample == -16'sd32767))
      else $error("sample outside saturation range");

endmodule

bind fsk_async_serial_modulator fskm_checker u_fskm_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .sample_valid (rsp_ch.sample_valid),
   .sample       (rsp_ch.sample),
   .clipped      (rsp_ch.clipped),
   .accepted     (rsp_ch.accepted)
);
